### rtl/core/mhc_pkg.sv
// Package with the types and constants shared by the message header checksum check.
`timescale 1ns / 1ps
package mhc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0]  MAGIC_RESET = 8'hCC;
    localparam logic [15:0] OFFSET_WORD = 16'hCCCC;
    localparam int unsigned SENSITIVE_BIT = 6;

    localparam logic [3:0] HDR_BYTES  = 4'd8;
    localparam logic [3:0] POS_MAGIC  = 4'd0;
    localparam logic [3:0] POS_OPT    = 4'd1;
    localparam logic [3:0] POS_LEN_HI = 4'd2;
    localparam logic [3:0] POS_LEN_LO = 4'd3;
    localparam logic [3:0] POS_CHK_HI = 4'd4;
    localparam logic [3:0] POS_CHK_LO = 4'd5;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        msg_valid;
        logic        incomplete;
        logic [7:0]  magic_seen;
        logic [7:0]  options_seen;
        logic [15:0] declared_length;
        logic [15:0] stored_checksum;
        logic [15:0] computed_checksum;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [3:0] pos;
        logic       second;
    } t_cls_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/core/message_header_checksum_check_core.sv
// Top level of the message header checksum check: front end, queue and back end.
//
//   Channel  Direction  Handshake                Payload
//   in       input      i_in_valid / o_in_stall  i_in_item  (byte, last mark)
//   out      output     o_out_valid / i_out_stall o_out_item (header, checksum, flags)
//   cfg      input      i_cfg_wr_en              i_cfg_wr_data (expected magic)
//
// One byte is accepted per cycle while the byte queue has room.
// A result item is registered in the back end when its last byte leaves the queue,
// which waits while a stalled result is still held.
// The back end retires one queued byte per cycle, but holds a last byte while a result is stalled.
// The input stalls only when the queue of QueueDepth entries is full.
// Reset is synchronous and clears the queue, the running sum and the output valid flag.
`timescale 1ns / 1ps
module message_header_checksum_check_core #(
    parameter int unsigned QueueDepth = mhc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mhc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mhc_pkg::t_out_item o_out_item
);

    logic               push;
    logic               pop;
    mhc_pkg::t_cls_item push_item;
    mhc_pkg::t_cls_item q_head;
    mhc_pkg::t_q_status q_status;

    mhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_item (push_item)
    );

    mhc_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    mhc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_status    (q_status),
        .i_q_head      (q_head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

endmodule

### rtl/core/mhc_front.sv
// Front end that accepts message bytes and tags each with its header position and pair half.
`timescale 1ns / 1ps
module mhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mhc_pkg::t_in_item   i_in_item,
    input  mhc_pkg::t_q_status  i_q_status,
    output logic                o_in_stall,
    output logic                o_push,
    output mhc_pkg::t_cls_item  o_push_item
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       r_second;
    logic       n_second;

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_push_item.data   = i_in_item.byte_in;
        o_push_item.last   = i_in_item.last_byte;
        o_push_item.pos    = r_pos;
        o_push_item.second = r_second;
    end

    always_comb begin
        n_pos    = r_pos;
        n_second = r_second;
        if (o_push) begin
            if (i_in_item.last_byte) begin
                n_pos    = '0;
                n_second = 1'b0;
            end else begin
                n_second = !r_second;
                if (r_pos < mhc_pkg::HDR_BYTES) begin
                    n_pos = r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_second <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_second <= n_second;
        end
    end

endmodule

### rtl/core/mhc_fifo.sv
// Short queue of tagged bytes between the front end and the back end.
`timescale 1ns / 1ps
module mhc_fifo #(
    parameter int unsigned Depth = mhc_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mhc_pkg::t_cls_item  i_push_item,
    input  logic                i_pop,
    output mhc_pkg::t_cls_item  o_head,
    output mhc_pkg::t_q_status  o_status
);

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    mhc_pkg::t_cls_item r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CntW'(Depth));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/core/mhc_back.sv
// Back end that captures the header, keeps the checksum and registers the result item.
`timescale 1ns / 1ps
module mhc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  mhc_pkg::t_q_status  i_q_status,
    input  mhc_pkg::t_cls_item  i_q_head,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output mhc_pkg::t_out_item  o_out_item
);

    logic [7:0]  r_expected_magic;
    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [7:0]  r_held;
    logic [7:0]  r_magic;
    logic [7:0]  r_options;
    logic [15:0] r_length;
    logic [15:0] r_checksum;
    logic [7:0]  n_magic;
    logic [7:0]  n_options;
    logic [15:0] n_length;
    logic [15:0] n_checksum;
    logic        r_out_valid;
    logic        n_out_valid;
    mhc_pkg::t_out_item r_out_item;
    mhc_pkg::t_out_item n_out_item;

    logic        out_free;
    logic [15:0] word;
    logic [16:0] raw_sum;
    logic [15:0] folded;
    logic [15:0] final_sum;
    logic [15:0] computed;
    logic        complete;
    logic        sensitive;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = !i_q_status.empty && (!i_q_head.last || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        if (!i_q_head.second) begin
            word = {i_q_head.data, 8'h00};
        end else if (i_q_head.pos == mhc_pkg::POS_CHK_LO) begin
            word = mhc_pkg::OFFSET_WORD;
        end else begin
            word = {r_held, i_q_head.data};
        end
        raw_sum   = {1'b0, r_sum} + {1'b0, word};
        folded    = raw_sum[15:0] + {15'd0, raw_sum[16]};
        final_sum = folded;
        computed  = ~final_sum;
    end

    always_comb begin
        n_magic    = r_magic;
        n_options  = r_options;
        n_length   = r_length;
        n_checksum = r_checksum;
        case (i_q_head.pos)
            mhc_pkg::POS_MAGIC:  n_magic          = i_q_head.data;
            mhc_pkg::POS_OPT:    n_options        = i_q_head.data;
            mhc_pkg::POS_LEN_HI: n_length[15:8]   = i_q_head.data;
            mhc_pkg::POS_LEN_LO: n_length[7:0]    = i_q_head.data;
            mhc_pkg::POS_CHK_HI: n_checksum[15:8] = i_q_head.data;
            mhc_pkg::POS_CHK_LO: n_checksum[7:0]  = i_q_head.data;
            default: ;
        endcase
    end

    always_comb begin
        complete  = (i_q_head.pos >= (mhc_pkg::HDR_BYTES - 4'd1));
        sensitive = n_options[mhc_pkg::SENSITIVE_BIT];
        n_out_item = '0;
        if (!complete) begin
            n_out_item.incomplete = 1'b1;
        end else begin
            n_out_item.msg_valid = (n_magic == r_expected_magic)
                && (!sensitive || (computed == n_checksum));
            n_out_item.magic_seen        = n_magic;
            n_out_item.options_seen      = n_options;
            n_out_item.declared_length   = n_length;
            n_out_item.stored_checksum   = n_checksum;
            n_out_item.computed_checksum = computed;
        end
    end

    always_comb begin
        n_sum = r_sum;
        if (o_pop) begin
            if (i_q_head.last) begin
                n_sum = '0;
            end else if (i_q_head.second) begin
                n_sum = folded;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && i_q_head.last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_magic    <= n_magic;
            r_options  <= n_options;
            r_length   <= n_length;
            r_checksum <= n_checksum;
            if (!i_q_head.second) begin
                r_held <= i_q_head.data;
            end
        end
        if (o_pop && i_q_head.last) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= mhc_pkg::MAGIC_RESET;
            r_sum            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected_magic <= i_cfg_wr_data;
            end
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/mhc_checker.sv
// Port-level checker for the message header checksum check and its bind.
`timescale 1ns / 1ps
module mhc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mhc_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled result item changed or dropped.");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result item shown right after reset.");

    a_incomplete_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.incomplete |->
            !o_out_item.msg_valid && (o_out_item.computed_checksum == 16'd0)
            && (o_out_item.magic_seen == 8'd0))
        else $error("Short message reported with nonzero fields.");

    a_sensitive_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.msg_valid
            && o_out_item.options_seen[mhc_pkg::SENSITIVE_BIT] |->
            (o_out_item.computed_checksum == o_out_item.stored_checksum))
        else $error("Sensitive message passed with a checksum mismatch.");

endmodule

bind message_header_checksum_check_core mhc_checker u_mhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
